/* hdl/psst_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted sequence table package
// Transaction field types, operation codes and the compare result shared by
// the sequencer and the compare unit.
// ----------------------------------------------------------------------------
package psst_pkg;

  localparam int OP_BITS   = 3;
  localparam int POS_BITS  = 9;
  localparam int DATA_BITS = 32;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_INS_POS  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_INS_SORT = 3'd1;
  localparam logic [OP_BITS-1:0] OP_ERASE    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_REMOVE   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_GET      = 3'd4;
  localparam logic [OP_BITS-1:0] OP_SET      = 3'd5;
  localparam logic [OP_BITS-1:0] OP_FIND     = 3'd6;

  typedef struct packed {
    logic [OP_BITS-1:0]   operation;
    logic [POS_BITS-1:0]  position;
    logic [DATA_BITS-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [POS_BITS-1:0]  result_index;
    logic [DATA_BITS-1:0] read_value;
    logic [POS_BITS-1:0]  removed_count;
    logic [POS_BITS-1:0]  length;
  } rsp_t;

  // Outcome of one compare of a stored entry against the key
  typedef struct packed {
    logic eq;  // key equals entry
    logic le;  // key is not greater than entry
  } cmp_res_t;

endpackage

/* hdl/psst_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/psst_cmp.sv */
// ----------------------------------------------------------------------------
// Shared compare unit
// Compares the entry just read from the store against the transaction key,
// giving equality and key-not-greater for the scan, remove and sorted insert.
// ----------------------------------------------------------------------------
module psst_cmp #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0]   entry_i,
  input  logic [WIDTH-1:0]   key_i,
  output psst_pkg::cmp_res_t res_o
);

  // Unsigned compare of key against entry
  always_comb begin
    res_o.eq = (key_i == entry_i);
    res_o.le = (key_i <= entry_i);
  end

endmodule

/* hdl/positional_sorted_sequence_table_top.sv */
// ----------------------------------------------------------------------------
// Positional sorted sequence table
// Ordered list of up to CAPACITY values held in one RAM, worked on by a small
// sequencer around a single compare unit.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low; its result is
// shown on rsp_o for exactly one cycle with done_o high, and the receiver
// cannot stall it. The store is a RAM with one write and one read port, so
// shifting and scanning move one entry per cycle. A sorted insert scans only
// up to the insertion point, and the shift takes over from there.
// The next transaction may be started in the strobe cycle.
// ----------------------------------------------------------------------------
module positional_sorted_sequence_table_top #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  psst_pkg::req_t req_i,
  output logic           done_o,
  output psst_pkg::rsp_t rsp_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int IW = (CW > psst_pkg::POS_BITS) ? CW : psst_pkg::POS_BITS;
  localparam logic [IW-1:0] CAP_X = IW'(CAPACITY);
  localparam logic [IW-1:0] ONE_X = IW'(1);
  localparam logic [IW-1:0] TWO_X = IW'(2);

  // Sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_REMOVE   = 3'd2;
  localparam logic [2:0] ST_SHIFT_UP = 3'd3;
  localparam logic [2:0] ST_INS_WR   = 3'd4;
  localparam logic [2:0] ST_SHIFT_DN = 3'd5;
  localparam logic [2:0] ST_GET_WAIT = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         done_q, done_d;
  logic [psst_pkg::OP_BITS-1:0] op_q, op_d;
  logic [VALUE_BITS-1:0]        val_q, val_d;
  logic [IW-1:0]                k_q, k_d;
  logic [IW-1:0]                w_q, w_d;
  logic [IW-1:0]                ins_q, ins_d;
  psst_pkg::rsp_t               rsp_q, rsp_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [VALUE_BITS-1:0] ram_rdata;
  psst_pkg::cmp_res_t    cmp;

  logic [63:0]           in_wide;
  logic [63:0]           rd_wide;
  logic [VALUE_BITS-1:0] in_val;
  logic [IW-1:0]         pos_x;
  logic [IW-1:0]         cnt_x;
  logic [IW-1:0]         last_x;

  // Widen and narrow the value fields
  assign in_wide = 64'(req_i.item_value);
  assign in_val  = in_wide[VALUE_BITS-1:0];
  assign rd_wide = 64'(ram_rdata);
  assign pos_x   = IW'(req_i.position);
  assign cnt_x   = IW'(cnt_q);
  assign last_x  = cnt_x - ONE_X;

  psst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  psst_cmp #(
    .WIDTH (VALUE_BITS)
  ) u_cmp (
    .entry_i (ram_rdata),
    .key_i   (val_q),
    .res_o   (cmp)
  );

  // Sequencer: one entry read, compared or moved per cycle
  always_comb begin
    logic [IW-1:0] ra;
    logic [IW-1:0] wa;
    logic [IW-1:0] p;
    logic [IW-1:0] wn;
    logic [IW-1:0] rem;
    logic          place;

    state_d   = state_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    op_d      = op_q;
    val_d     = val_q;
    k_d       = k_q;
    w_d       = w_q;
    ins_d     = ins_q;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_wdata = val_q;
    ra        = '0;
    wa        = '0;
    p         = '0;
    wn        = '0;
    rem       = '0;
    place     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d   = req_i.operation;
          val_d  = in_val;
          done_d = 1'b1;
          rsp_d  = '0;
          case (req_i.operation)
            psst_pkg::OP_INS_POS: begin
              if (pos_x <= cnt_x && cnt_x < CAP_X) begin
                done_d = 1'b0;
                ins_d  = pos_x;
                if (pos_x == cnt_x) begin
                  state_d = ST_INS_WR;
                end else begin
                  ra      = last_x;
                  k_d     = cnt_x;
                  state_d = ST_SHIFT_UP;
                end
              end
            end
            psst_pkg::OP_INS_SORT: begin
              if (cnt_x < CAP_X) begin
                done_d = 1'b0;
                k_d    = '0;
                if (cnt_q == '0) begin
                  ins_d   = '0;
                  state_d = ST_INS_WR;
                end else begin
                  state_d = ST_SCAN;
                end
              end
            end
            psst_pkg::OP_ERASE: begin
              if (pos_x < cnt_x) begin
                if (pos_x == last_x) begin
                  cnt_d    = cnt_q - CW'(1);
                  rsp_d.ok = 1'b1;
                end else begin
                  done_d  = 1'b0;
                  ra      = pos_x + ONE_X;
                  k_d     = pos_x;
                  state_d = ST_SHIFT_DN;
                end
              end
            end
            psst_pkg::OP_REMOVE: begin
              if (cnt_q != '0) begin
                done_d  = 1'b0;
                k_d     = '0;
                w_d     = '0;
                state_d = ST_REMOVE;
              end
            end
            psst_pkg::OP_GET: begin
              if (pos_x < cnt_x) begin
                done_d  = 1'b0;
                ra      = pos_x;
                state_d = ST_GET_WAIT;
              end
            end
            psst_pkg::OP_SET: begin
              if (pos_x < cnt_x) begin
                ram_we    = 1'b1;
                wa        = pos_x;
                ram_wdata = in_val;
                rsp_d.ok  = 1'b1;
              end
            end
            psst_pkg::OP_FIND: begin
              if (cnt_q != '0) begin
                done_d  = 1'b0;
                k_d     = '0;
                state_d = ST_SCAN;
              end
            end
            default: begin
              rsp_d = '0;
            end
          endcase
        end
      end

      // Walk the entries in order; read ahead one entry
      ST_SCAN: begin
        ra = k_q + ONE_X;
        if (op_q == psst_pkg::OP_FIND) begin
          if (cmp.eq) begin
            rsp_d.ok           = 1'b1;
            rsp_d.result_index = k_q[psst_pkg::POS_BITS-1:0];
            done_d             = 1'b1;
            state_d            = ST_IDLE;
          end else if (k_q == last_x) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + ONE_X;
          end
        end else begin
          if (cmp.le) begin
            p     = k_q;
            place = 1'b1;
          end else if (k_q == last_x) begin
            p     = cnt_x;
            place = 1'b1;
          end else begin
            k_d = k_q + ONE_X;
          end
          // Insertion point known: start the upward shift
          if (place) begin
            ins_d = p;
            if (p == cnt_x) begin
              state_d = ST_INS_WR;
            end else begin
              ra      = last_x;
              k_d     = cnt_x;
              state_d = ST_SHIFT_UP;
            end
          end
        end
      end

      // Compact the entries that differ from the key
      ST_REMOVE: begin
        ra = k_q + ONE_X;
        wn = w_q;
        if (!cmp.eq) begin
          ram_we    = 1'b1;
          wa        = w_q;
          ram_wdata = ram_rdata;
          wn        = w_q + ONE_X;
        end
        w_d = wn;
        if (k_q == last_x) begin
          rem                 = cnt_x - wn;
          cnt_d               = wn[CW-1:0];
          rsp_d.ok            = (rem != '0);
          rsp_d.removed_count = rem[psst_pkg::POS_BITS-1:0];
          done_d              = 1'b1;
          state_d             = ST_IDLE;
        end else begin
          k_d = k_q + ONE_X;
        end
      end

      // Move each entry up by one, top first
      ST_SHIFT_UP: begin
        ram_we    = 1'b1;
        wa        = k_q;
        ram_wdata = ram_rdata;
        ra        = k_q - TWO_X;
        if (k_q - ONE_X == ins_q) begin
          state_d = ST_INS_WR;
        end else begin
          k_d = k_q - ONE_X;
        end
      end

      // Drop the new value into the gap
      ST_INS_WR: begin
        ram_we             = 1'b1;
        wa                 = ins_q;
        ram_wdata          = val_q;
        cnt_d              = cnt_q + CW'(1);
        rsp_d.ok           = 1'b1;
        rsp_d.result_index = ins_q[psst_pkg::POS_BITS-1:0];
        done_d             = 1'b1;
        state_d            = ST_IDLE;
      end

      // Move each entry down by one, bottom first
      ST_SHIFT_DN: begin
        ram_we    = 1'b1;
        wa        = k_q;
        ram_wdata = ram_rdata;
        ra        = k_q + TWO_X;
        if (k_q + TWO_X == cnt_x) begin
          cnt_d    = cnt_q - CW'(1);
          rsp_d.ok = 1'b1;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          k_d = k_q + ONE_X;
        end
      end

      ST_GET_WAIT: begin
        rsp_d.ok         = 1'b1;
        rsp_d.read_value = rd_wide[psst_pkg::DATA_BITS-1:0];
        done_d           = 1'b1;
        state_d          = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    ram_raddr = ra[AW-1:0];
    ram_waddr = wa[AW-1:0];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Working registers and result hold
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    k_q   <= k_d;
    w_q   <= w_d;
    ins_q <= ins_d;
    rsp_q <= rsp_d;
  end

  // Length follows the entry count, which holds through the strobe cycle
  always_comb begin
    rsp_o        = rsp_q;
    rsp_o.length = cnt_x[psst_pkg::POS_BITS-1:0];
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

/* bench/positional_sorted_sequence_table_top_test.sv */
// ----------------------------------------------------------------------------
// Positional sorted sequence table testbench
// Drives a directed table followed by random churn, fill-to-full, drain and
// final churn phases through the start/busy port, and checks each done strobe
// field by field against an in-order prediction of the sequence contents.
// ----------------------------------------------------------------------------
module positional_sorted_sequence_table_top_test;

  localparam int OP_BITS        = psst_pkg::OP_BITS;
  localparam int POS_BITS       = psst_pkg::POS_BITS;
  localparam int DATA_BITS      = psst_pkg::DATA_BITS;
  localparam int CAP            = 256;
  localparam int DIR_ROWS       = 25;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;

  // Code with no meaning: must leave the sequence alone
  localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;

  localparam psst_pkg::rsp_t NO_RSP = '0;

  typedef struct {
    logic [OP_BITS-1:0]   op;
    logic [POS_BITS-1:0]  pos;
    logic [DATA_BITS-1:0] val;
    bit                   typed;
    psst_pkg::rsp_t       want;
  } dir_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  psst_pkg::req_t req_i;
  logic           done_o;
  psst_pkg::rsp_t rsp_o;

  // Predicted contents of the sequence
  logic [DATA_BITS-1:0] seq_mem [CAP];
  int unsigned          seq_len = 0;

  psst_pkg::rsp_t op_outcome_q [$];
  int unsigned    fail_count = 0;
  int unsigned    burst_left = 0;
  int unsigned    idle_cycles = 0;

  // Directed transactions: outcome typed in where it is obvious, else predicted
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{psst_pkg::OP_GET,      9'd0,   32'h0000_0000, 1'b1,
      '{1'b0, 9'd0, 32'd0, 9'd0, 9'd0}},
    '{psst_pkg::OP_ERASE,    9'd0,   32'h0000_0000, 1'b1,
      '{1'b0, 9'd0, 32'd0, 9'd0, 9'd0}},
    '{psst_pkg::OP_SET,      9'd0,   32'hDEAD_BEEF, 1'b1,
      '{1'b0, 9'd0, 32'd0, 9'd0, 9'd0}},
    '{psst_pkg::OP_FIND,     9'd0,   32'h0000_0000, 1'b1,
      '{1'b0, 9'd0, 32'd0, 9'd0, 9'd0}},
    '{psst_pkg::OP_REMOVE,   9'd0,   32'h0000_0000, 1'b1,
      '{1'b0, 9'd0, 32'd0, 9'd0, 9'd0}},
    '{psst_pkg::OP_INS_POS,  9'd1,   32'h0000_0005, 1'b1,
      '{1'b0, 9'd0, 32'd0, 9'd0, 9'd0}},
    '{psst_pkg::OP_INS_POS,  9'd0,   32'hFFFF_FFFF, 1'b1,
      '{1'b1, 9'd0, 32'd0, 9'd0, 9'd1}},
    '{psst_pkg::OP_INS_POS,  9'd1,   32'h0000_0000, 1'b1,
      '{1'b1, 9'd1, 32'd0, 9'd0, 9'd2}},
    '{psst_pkg::OP_INS_SORT, 9'h1FF, 32'h8000_0000, 1'b0, NO_RSP},
    '{psst_pkg::OP_INS_SORT, 9'd0,   32'h0000_0000, 1'b0, NO_RSP},
    '{psst_pkg::OP_GET,      9'h1FF, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 9'd0, 32'd0, 9'd0, 9'd4}},
    '{OP_UNUSED,             9'h1FF, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 9'd0, 32'd0, 9'd0, 9'd4}},
    '{psst_pkg::OP_GET,      9'd1,   32'h0000_0000, 1'b0, NO_RSP},
    '{psst_pkg::OP_FIND,     9'd0,   32'h0000_0000, 1'b0, NO_RSP},
    '{psst_pkg::OP_FIND,     9'd0,   32'h1234_5678, 1'b0, NO_RSP},
    '{psst_pkg::OP_SET,      9'd3,   32'hFFFF_FFFF, 1'b0, NO_RSP},
    '{psst_pkg::OP_INS_POS,  9'd2,   32'hFFFF_FFFF, 1'b0, NO_RSP},
    '{psst_pkg::OP_REMOVE,   9'd0,   32'hFFFF_FFFF, 1'b0, NO_RSP},
    '{psst_pkg::OP_REMOVE,   9'd0,   32'h0000_0007, 1'b0, NO_RSP},
    '{psst_pkg::OP_ERASE,    9'd256, 32'h0000_0000, 1'b0, NO_RSP},
    '{psst_pkg::OP_ERASE,    9'd0,   32'h0000_0000, 1'b0, NO_RSP},
    '{psst_pkg::OP_INS_SORT, 9'd0,   32'hFFFF_FFFF, 1'b0, NO_RSP},
    '{psst_pkg::OP_GET,      9'd0,   32'h0000_0000, 1'b0, NO_RSP},
    '{psst_pkg::OP_ERASE,    9'd1,   32'h0000_0000, 1'b0, NO_RSP},
    '{psst_pkg::OP_INS_POS,  9'h100, 32'h7FFF_FFFF, 1'b0, NO_RSP}
  };

  positional_sorted_sequence_table_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Open a gap at position at and place the value there
  function automatic void seq_shift_in(int unsigned at, logic [DATA_BITS-1:0] v);
    for (int unsigned k = seq_len; k > at; k--) begin
      seq_mem[k] = seq_mem[k-1];
    end
    seq_mem[at] = v;
    seq_len++;
  endfunction

  // Apply one transaction to the predicted sequence and return its outcome
  function automatic psst_pkg::rsp_t seq_apply(psst_pkg::req_t r);
    psst_pkg::rsp_t       res;
    int unsigned          p;
    int unsigned          w;
    logic                 hit;
    logic [DATA_BITS-1:0] v;
    res = '0;
    p   = r.position;
    v   = r.item_value;
    hit = 1'b0;
    case (r.operation)
      psst_pkg::OP_INS_POS: begin
        if (p <= seq_len && seq_len < CAP) begin
          seq_shift_in(p, v);
          res.ok           = 1'b1;
          res.result_index = POS_BITS'(p);
        end
      end
      psst_pkg::OP_INS_SORT: begin
        if (seq_len < CAP) begin
          p = seq_len;
          for (int unsigned k = 0; k < seq_len && !hit; k++) begin
            if (v <= seq_mem[k]) begin
              p   = k;
              hit = 1'b1;
            end
          end
          seq_shift_in(p, v);
          res.ok           = 1'b1;
          res.result_index = POS_BITS'(p);
        end
      end
      psst_pkg::OP_ERASE: begin
        if (p < seq_len) begin
          for (int unsigned k = p; k + 1 < seq_len; k++) begin
            seq_mem[k] = seq_mem[k+1];
          end
          seq_len--;
          res.ok = 1'b1;
        end
      end
      psst_pkg::OP_REMOVE: begin
        w = 0;
        for (int unsigned k = 0; k < seq_len; k++) begin
          if (seq_mem[k] != v) begin
            seq_mem[w] = seq_mem[k];
            w++;
          end
        end
        res.removed_count = POS_BITS'(seq_len - w);
        res.ok            = (seq_len != w);
        seq_len           = w;
      end
      psst_pkg::OP_GET: begin
        if (p < seq_len) begin
          res.read_value = seq_mem[p];
          res.ok         = 1'b1;
        end
      end
      psst_pkg::OP_SET: begin
        if (p < seq_len) begin
          seq_mem[p] = v;
          res.ok     = 1'b1;
        end
      end
      psst_pkg::OP_FIND: begin
        for (int unsigned k = 0; k < seq_len && !hit; k++) begin
          if (seq_mem[k] == v) begin
            hit              = 1'b1;
            res.ok           = 1'b1;
            res.result_index = POS_BITS'(k);
          end
        end
      end
      default: begin
      end
    endcase
    res.length = POS_BITS'(seq_len);
    return res;
  endfunction

  // Pick a value: small pool for matches, stored entries, extremes, or anything
  function automatic logic [DATA_BITS-1:0] rand_value();
    logic [DATA_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 7);
      4, 5:       v = (seq_len != 0) ? seq_mem[$urandom_range(0, seq_len - 1)] : $urandom;
      6: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h0000_0000;
          1:       v = 32'hFFFF_FFFF;
          2:       v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  // Build one random transaction with the given insert and delete weights
  function automatic psst_pkg::req_t rand_item(int unsigned ins_pct, int unsigned del_pct);
    psst_pkg::req_t r;
    int unsigned    pick;
    pick         = $urandom_range(0, 99);
    r.item_value = rand_value();
    if (pick < ins_pct) begin
      r.operation = $urandom_range(0, 1) ? psst_pkg::OP_INS_SORT : psst_pkg::OP_INS_POS;
    end else if (pick < ins_pct + del_pct) begin
      r.operation = ($urandom_range(0, 3) == 0) ? psst_pkg::OP_REMOVE : psst_pkg::OP_ERASE;
    end else if (pick < 98) begin
      case ($urandom_range(0, 2))
        0:       r.operation = psst_pkg::OP_GET;
        1:       r.operation = psst_pkg::OP_SET;
        default: r.operation = psst_pkg::OP_FIND;
      endcase
    end else begin
      r.operation = OP_UNUSED;
    end
    // Mostly in range, now and then any position at all
    if ($urandom_range(0, 4) == 0) begin
      r.position = POS_BITS'($urandom);
    end else if (r.operation == psst_pkg::OP_INS_POS ||
                 r.operation == psst_pkg::OP_INS_SORT) begin
      r.position = POS_BITS'($urandom_range(0, seq_len));
    end else begin
      r.position = (seq_len != 0) ? POS_BITS'($urandom_range(0, seq_len - 1)) : '0;
    end
    return r;
  endfunction

  // Offer one transaction, holding it until taken; open a gap between bursts
  task automatic send_item(psst_pkg::req_t r, bit typed, psst_pkg::rsp_t typed_rsp);
    int unsigned    gap;
    logic [63:0]    noise;
    psst_pkg::rsp_t pred;
    if (burst_left == 0) begin
      gap   = $urandom_range(1, 8);
      noise = {$urandom, $urandom};
      start_i <= 1'b0;
      req_i   <= noise[$bits(psst_pkg::req_t)-1:0];
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pred = seq_apply(r);
    op_outcome_q.push_back(typed ? typed_rsp : pred);
  endtask

  // Hold off until every outstanding outcome has come back
  task automatic wait_all_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (op_outcome_q.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic check_field(string name, logic [DATA_BITS-1:0] want_v,
                             logic [DATA_BITS-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Compare each strobed result with the oldest outstanding outcome
  always @(posedge clk_i) begin : rsp_check
    psst_pkg::rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (op_outcome_q.size() == 0) begin
        $error("result strobed with no transaction outstanding");
        fail_count++;
      end else begin
        want = op_outcome_q.pop_front();
        check_field("ok", DATA_BITS'(want.ok), DATA_BITS'(rsp_o.ok));
        check_field("result_index", DATA_BITS'(want.result_index),
                    DATA_BITS'(rsp_o.result_index));
        check_field("read_value", want.read_value, rsp_o.read_value);
        check_field("removed_count", DATA_BITS'(want.removed_count),
                    DATA_BITS'(rsp_o.removed_count));
        check_field("length", DATA_BITS'(want.length), DATA_BITS'(rsp_o.length));
      end
    end
  end

  // Abort when nothing moves in either direction for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[positional_sorted_sequence_table_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned n;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item('{dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val},
                dir_rows[i].typed, dir_rows[i].want);
    end

    // Churn on a short sequence
    repeat (600) send_item(rand_item(seq_len > 24 ? 10 : 40, 30), 1'b0, NO_RSP);
    wait_all_results();

    // Fill to capacity, then work on the full table
    n = 0;
    while (seq_len < CAP && n < 1200) begin
      send_item(rand_item(85, 3), 1'b0, NO_RSP);
      n++;
    end
    repeat (40) send_item(rand_item(50, 4), 1'b0, NO_RSP);

    // Drain back to empty
    n = 0;
    while (seq_len != 0 && n < 600) begin
      send_item(rand_item(5, 70), 1'b0, NO_RSP);
      n++;
    end
    wait_all_results();

    repeat (250) send_item(rand_item(seq_len > 24 ? 10 : 40, 30), 1'b0, NO_RSP);

    // Let the last outcomes arrive and catch any stray strobe
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[positional_sorted_sequence_table_top] OK");
    end else begin
      $display("[positional_sorted_sequence_table_top] ERROR");
    end
    $finish;
  end

endmodule
